// ===== hdl/cpet_pkg.sv =====
// Package for the contact pair event tracker.
// Holds the transaction payload types, the table entry layout and the event codes.
// Has no dependencies.
package cpet_pkg;

  localparam int unsigned ID_W    = 8;
  localparam int unsigned COORD_W = 16;

  typedef logic        [ID_W-1:0]    id_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_STAY  = 2'd2,
    EV_STOP  = 2'd3
  } event_e;

  typedef struct packed {
    id_t    first_id;
    id_t    second_id;
    coord_t first_left;
    coord_t first_top;
    coord_t first_right;
    coord_t first_bottom;
    coord_t second_left;
    coord_t second_top;
    coord_t second_right;
    coord_t second_bottom;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic       table_full;
  } out_item_t;

  // One slot of the contact table: pair kept as (smaller id, larger id).
  typedef struct packed {
    logic valid;
    id_t  lo;
    id_t  hi;
  } pair_entry_t;

endpackage

// ===== hdl/contact_pair_event_tracker.sv =====
// Top level of the contact pair event tracker: overlap test, contact table and output register.
// Depends on cpet_pkg for payload types, table entry layout and event codes.
//
// Each input transaction carries two object ids and their world-space boxes. The block tests
// the boxes for overlap (inclusive edges; a box with min > max on either axis overlaps
// nothing), then looks the unordered id pair up in a table of current contacts held in one
// synchronous memory of PAIR_SLOTS entries with one write port and one read port. It returns
// exactly one result per transaction: start (pair recorded in the lowest free slot), stay,
// stop (pair removed) or none; start comes with table_full set when no slot was free and
// nothing was recorded.
// Operation: the table is scanned one slot per cycle through the memory read port. Each item
// goes through accept, the scan and write-back; the scan ends at the slot that holds the pair,
// or after every slot when the pair is absent. One item is in flight at a time; the finished
// result sits in an output register, so the next item is accepted while it waits.
// Write-back holds while an earlier result still waits in that register.
// After reset the block runs a clearing pass over every memory slot and holds in_stall_o high
// until it is done.
module contact_pair_event_tracker #(
  parameter int unsigned PAIR_SLOTS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cpet_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cpet_pkg::out_item_t  out_data_o
);

  import cpet_pkg::*;

  localparam int unsigned IDX_W   = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
  localparam int unsigned ENTRY_W = $bits(pair_entry_t);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAIR_SLOTS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_e;

  state_e            state_q;
  logic [IDX_W-1:0]  addr_q;       // scan read address, also the clearing pointer
  logic              iss_done_q;   // every slot has been read
  logic              rd_ok_q;      // rdata_q holds a slot of this scan
  logic [IDX_W-1:0]  rd_idx_q;     // slot that rdata_q came from
  logic              found_q;
  logic [IDX_W-1:0]  found_idx_q;
  logic              free_seen_q;
  logic [IDX_W-1:0]  free_idx_q;
  id_t               lo_q;
  id_t               hi_q;
  logic              hit_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic [ENTRY_W-1:0] mem_q [PAIR_SLOTS];
  logic [ENTRY_W-1:0] rdata_q;

  // Overlap test on the incoming transaction, registered at accept.
  logic in_hit;
  logic in_accept;
  id_t  in_lo;
  id_t  in_hi;

  always_comb begin
    in_hit = (in_data_i.first_left  <= in_data_i.first_right)  &&
             (in_data_i.first_top   <= in_data_i.first_bottom) &&
             (in_data_i.second_left <= in_data_i.second_right) &&
             (in_data_i.second_top  <= in_data_i.second_bottom) &&
             (in_data_i.first_left  <= in_data_i.second_right) &&
             (in_data_i.second_left <= in_data_i.first_right)  &&
             (in_data_i.first_top   <= in_data_i.second_bottom) &&
             (in_data_i.second_top  <= in_data_i.first_bottom);
    // Order the pair so (a,b) and (b,a) land on the same entry.
    if (in_data_i.first_id < in_data_i.second_id) begin
      in_lo = in_data_i.first_id;
      in_hi = in_data_i.second_id;
    end else begin
      in_lo = in_data_i.second_id;
      in_hi = in_data_i.first_id;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Slot compare on the registered read data.
  pair_entry_t rd_entry;
  logic        rd_match;

  assign rd_entry = pair_entry_t'(rdata_q);
  assign rd_match = rd_entry.valid && (rd_entry.lo == lo_q) && (rd_entry.hi == hi_q);

  // Event decision and write-back once the scan is over.
  logic        out_free;
  logic        do_decide;
  out_item_t   result;
  logic        wr_insert;
  logic        wr_remove;
  logic        mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  pair_entry_t mem_wdata;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign do_decide = (state_q == ST_DECIDE) && out_free;

  always_comb begin
    result.event_res  = EV_NONE;
    result.table_full = 1'b0;
    wr_insert         = 1'b0;
    wr_remove         = 1'b0;
    if (hit_q && !found_q) begin
      result.event_res  = EV_START;
      result.table_full = !free_seen_q;
      wr_insert         = free_seen_q;
    end else if (hit_q) begin
      result.event_res  = EV_STAY;
    end else if (found_q) begin
      result.event_res  = EV_STOP;
      wr_remove         = 1'b1;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = '0;
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (do_decide && wr_insert) begin
      mem_we          = 1'b1;
      mem_waddr       = free_idx_q;
      mem_wdata.valid = 1'b1;
      mem_wdata.lo    = lo_q;
      mem_wdata.hi    = hi_q;
    end else if (do_decide && wr_remove) begin
      mem_we    = 1'b1;
      mem_waddr = found_idx_q;
    end
  end

  // Contact table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[addr_q];
  end

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      iss_done_q  <= 1'b0;
      rd_ok_q     <= 1'b0;
      rd_idx_q    <= '0;
      found_q     <= 1'b0;
      found_idx_q <= '0;
      free_seen_q <= 1'b0;
      free_idx_q  <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Drop the result once the consumer takes it, unless a new one replaces it.
      if (out_valid_q && !out_stall_i && !do_decide) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          if (addr_q == LAST_IDX) begin
            addr_q  <= '0;
            state_q <= ST_IDLE;
          end else begin
            addr_q <= addr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            lo_q        <= in_lo;
            hi_q        <= in_hi;
            hit_q       <= in_hit;
            addr_q      <= '0;
            iss_done_q  <= 1'b0;
            rd_ok_q     <= 1'b0;
            found_q     <= 1'b0;
            free_seen_q <= 1'b0;
            state_q     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue one read per cycle, then check its data in the next cycle.
          rd_ok_q  <= !iss_done_q;
          rd_idx_q <= addr_q;
          if (!iss_done_q) begin
            if (addr_q == LAST_IDX) begin
              iss_done_q <= 1'b1;
            end else begin
              addr_q <= addr_q + 1'b1;
            end
          end
          if (rd_ok_q) begin
            if (rd_match) begin
              found_q     <= 1'b1;
              found_idx_q <= rd_idx_q;
              state_q     <= ST_DECIDE;
            end else begin
              if (!rd_entry.valid && !free_seen_q) begin
                free_seen_q <= 1'b1;
                free_idx_q  <= rd_idx_q;
              end
              if (rd_idx_q == LAST_IDX) begin
                state_q <= ST_DECIDE;
              end
            end
          end
        end
        ST_DECIDE: begin
          // Hold here while an earlier result is still waiting.
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= result;
            rd_ok_q     <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new result never overwrites one the consumer has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECIDE && out_valid_q && out_stall_i) |=> $stable(out_q))
    else $error("output result overwritten while stalled");

  // table_full only ever accompanies a start event.
  a_full_with_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.table_full) |-> (out_q.event_res == EV_START))
    else $error("table_full without start");

  // The table is only written in the clearing pass or at write-back, never mid-scan.
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !mem_we)
    else $error("table written during scan");

  // A found pair never produces a start event.
  a_found_not_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_decide && found_q) |-> (result.event_res == EV_STAY || result.event_res == EV_STOP))
    else $error("recorded pair reported as start or none");

endmodule
